// ===== hw/rtl/i2cmb_pkg.sv =====
// Shared types and constants for the I2C register-burst master.
// No dependencies; imported by the top level, the sequencer and the write buffer.
`default_nettype none

package i2cmb_pkg;

  // Write buffer depth and derived widths
  localparam int BUF_DEPTH = 16;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);            // holds 0..BUF_DEPTH
  localparam int BC_W      = $clog2(BUF_DEPTH + 2);            // holds 0..BUF_DEPTH+1
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LEN_W     = 5;                                // burst_len field
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [15:0] ACK_TMO_RST = 16'd1000;
  localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TMO  = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       reg_addr;
    logic [LEN_W-1:0] burst_len;
    logic [7:0]       wr_byte;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] ack_tmo;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } bufwr_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listen;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       ack_missing;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_register_burst.sv =====
// Top level of the I2C register-burst master: input register, sequencer,
// write buffer, output register and config registers. Depends on i2cmb_pkg,
// i2cmb_seq and i2cmb_wbuf.
//
// Usage:
//   - in_ channel: one beat per request. A tick beat plays one bit-delay slot
//     of the bus; load beats fill the write buffer; start beats launch a burst
//     write or burst read while the bus is idle.
//   - out_ channel: exactly one result beat per input beat, in order. It
//     carries the SCL/SDA levels of the slot, read data with its last flag,
//     the sticky ACK timeout flag and the busy flag.
//   - cfg_ channel: device address (index 0), ACK timeout (index 1); always
//     ready. The user writes it only while the block is idle; not enforced.
// Path: an accepted beat is held in the input register, and its result then
//   in the output register; out_stall can hold it in between.
// Throughput: one beat per cycle while out_stall is low; the sequencer step
//   between the two registers is combinational.
// Reset (rst_n low, synchronous): both pipeline registers empty, bus idle,
//   buffer fill count zero, device address 0, ACK timeout 1000.
// Stall: while out_stall holds, the result holds; the input register keeps
//   its beat and in_stall rises once that register is full.
`default_nettype none

module i2c_master_register_burst
  import i2cmb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [7:0]           in_reg_addr,
  input  wire logic [LEN_W-1:0]     in_burst_len,
  input  wire logic [7:0]           in_wr_byte,
  input  wire logic                 in_sda_in,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scl_level,
  output logic                      out_sda_level,
  output logic                      out_sda_listen,
  output logic [7:0]                out_rd_byte,
  output logic                      out_rd_valid,
  output logic                      out_rd_last,
  output logic                      out_ack_missing,
  output logic                      out_busy_res,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  cfg_t             cfg_r;

  logic             in_take;
  logic             s1_adv;
  logic             out_free;

  logic [IDX_W-1:0] buf_rd_addr;
  logic [7:0]       buf_rd_data;
  bufwr_t           buf_wr;
  result_t          seq_res;

  // Output register frees when empty or when its beat leaves this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.req_type  <= in_req_type;
      s1_item_r.reg_addr  <= in_reg_addr;
      s1_item_r.burst_len <= in_burst_len;
      s1_item_r.wr_byte   <= in_wr_byte;
      s1_item_r.sda_in    <= in_sda_in;
    end
    if (s1_adv) begin
      out_res_r <= seq_res;
    end
  end

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr <= '0;
      cfg_r.ack_tmo  <= ACK_TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEV_ADDR: cfg_r.dev_addr <= cfg_data[7:0];
        REG_ACK_TMO:  cfg_r.ack_tmo  <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cmb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .item        (s1_item_r),
    .cfg         (cfg_r),
    .buf_rd_data (buf_rd_data),
    .buf_rd_addr (buf_rd_addr),
    .buf_wr      (buf_wr),
    .res         (seq_res)
  );

  i2cmb_wbuf u_wbuf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_scl_level   = out_res_r.scl_level;
  assign out_sda_level   = out_res_r.sda_level;
  assign out_sda_listen  = out_res_r.sda_listen;
  assign out_rd_byte     = out_res_r.rd_byte;
  assign out_rd_valid    = out_res_r.rd_valid;
  assign out_rd_last     = out_res_r.rd_last;
  assign out_ack_missing = out_res_r.ack_missing;
  assign out_busy_res    = out_res_r.busy_res;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cmb_wbuf.sv =====
// Write byte buffer: one write port, one combinational read port.
// Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_wbuf
  import i2cmb_pkg::*;
(
  input  wire logic             clk,
  input  wire bufwr_t           wr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic [7:0]            rd_data
);

  logic [7:0] mem_r [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = mem_r[rd_addr];

endmodule

`default_nettype wire

// ===== hw/rtl/i2cmb_seq.sv =====
// Bus sequencer: phase machine, bit/byte counters, shift register, ACK poll.
// Depends on i2cmb_pkg; drives the write buffer in i2cmb_wbuf.
`default_nettype none

module i2cmb_seq
  import i2cmb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire item_t            item,
  input  wire cfg_t             cfg,
  input  wire logic [7:0]       buf_rd_data,
  output logic [IDX_W-1:0]      buf_rd_addr,
  output bufwr_t                buf_wr,
  output result_t               res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_START2, PH_START3, PH_SEND_LO, PH_SEND_HI,
    PH_ACK_REL, PH_ACK_POLL, PH_RS, PH_RECV_LO, PH_RECV_HI,
    PH_MACK_LO, PH_MACK_HI, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [BC_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic [7:0]       reg_addr_r, reg_addr_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             is_read_r, is_read_nxt;
  logic             ack_flag_r, ack_flag_nxt;

  logic             do_ack;
  logic [BC_W-1:0]  bc_inc;
  logic [BC_W-1:0]  idx_m1;
  logic [15:0]      wait_inc;
  logic [CMP_W-1:0] len_sat;
  logic [3:0]       bit_inc;
  logic [7:0]       shift_in;
  logic             nack_bit;

  assign bc_inc   = byte_cnt_r + BC_W'(1);
  assign idx_m1   = byte_cnt_r - BC_W'(1);
  assign bit_inc  = bit_cnt_r + 4'd1;
  assign shift_in = {shift_r[6:0], item.sda_in};
  assign wait_inc = (wait_r != WAIT_MAX) ? wait_r + 16'd1 : wait_r;
  assign nack_bit = (byte_cnt_r >= BC_W'(len_r));

  // Buffer read: first data byte after the register address, else idx-1
  assign buf_rd_addr = (byte_cnt_r == BC_W'(1)) ? '0 : IDX_W'(idx_m1);

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    fill_nxt     = fill_r;
    wait_nxt     = wait_r;
    reg_addr_nxt = reg_addr_r;
    len_nxt      = len_r;
    is_read_nxt  = is_read_r;
    ack_flag_nxt = ack_flag_r;
    do_ack       = 1'b0;
    len_sat      = CMP_W'(item.burst_len);
    buf_wr       = '0;
    res          = '0;

    // Levels of the slot about to be played
    case (phase_r)
      PH_START2:   begin res.scl_level = 1'b1; res.sda_level = 1'b0; end
      PH_START3:   begin res.scl_level = 1'b0; res.sda_level = 1'b0; end
      PH_SEND_LO:  begin res.scl_level = 1'b0; res.sda_level = shift_r[7]; end
      PH_SEND_HI:  begin res.scl_level = 1'b1; res.sda_level = shift_r[7]; end
      PH_ACK_REL:  begin
        res.scl_level = 1'b0; res.sda_level = 1'b1; res.sda_listen = 1'b1;
      end
      PH_ACK_POLL: begin
        res.scl_level = 1'b1; res.sda_level = 1'b1; res.sda_listen = 1'b1;
      end
      PH_RS:       begin res.scl_level = 1'b0; res.sda_level = 1'b1; end
      PH_RECV_LO:  begin
        res.scl_level = 1'b0; res.sda_level = 1'b1; res.sda_listen = 1'b1;
      end
      PH_RECV_HI:  begin
        res.scl_level = 1'b1; res.sda_level = 1'b1; res.sda_listen = 1'b1;
      end
      PH_MACK_LO:  begin res.scl_level = 1'b0; res.sda_level = nack_bit; end
      PH_MACK_HI:  begin res.scl_level = 1'b1; res.sda_level = nack_bit; end
      PH_STOP_A:   begin res.scl_level = 1'b0; res.sda_level = 1'b0; end
      PH_STOP_B:   begin res.scl_level = 1'b1; res.sda_level = 1'b0; end
      default:     begin res.scl_level = 1'b1; res.sda_level = 1'b1; end
    endcase

    if (step) begin
      case (item.req_type)
        REQ_LOAD: begin
          if (phase_r == PH_IDLE && fill_r < CNT_W'(BUF_DEPTH)) begin
            buf_wr.en   = 1'b1;
            buf_wr.addr = IDX_W'(fill_r);
            buf_wr.data = item.wr_byte;
            fill_nxt    = fill_r + CNT_W'(1);
          end
        end
        REQ_WRITE, REQ_READ: begin
          if (phase_r == PH_IDLE) begin
            is_read_nxt = (item.req_type == REQ_READ);
            if (len_sat > CMP_W'(BUF_DEPTH)) begin
              len_sat = CMP_W'(BUF_DEPTH);
            end
            if (is_read_nxt && len_sat == '0) begin
              len_sat = CMP_W'(1);
            end
            len_nxt      = CNT_W'(len_sat);
            reg_addr_nxt = item.reg_addr;
            if (!is_read_nxt) begin
              fill_nxt = '0;
            end
            ack_flag_nxt = 1'b0;
            wait_nxt     = '0;
            byte_cnt_nxt = '0;
            bit_cnt_nxt  = '0;
            phase_nxt    = PH_START1;
          end
        end
        default: begin
          case (phase_r)
            PH_START1: phase_nxt = PH_START2;
            PH_START2: phase_nxt = PH_START3;
            PH_START3: begin
              // second start of a read carries the read address
              if (is_read_r && byte_cnt_r == BC_W'(1)) begin
                shift_nxt    = cfg.dev_addr + 8'd1;
                byte_cnt_nxt = BC_W'(2);
              end else begin
                shift_nxt    = cfg.dev_addr;
                byte_cnt_nxt = '0;
              end
              bit_cnt_nxt = '0;
              phase_nxt   = PH_SEND_LO;
            end
            PH_SEND_LO: phase_nxt = PH_SEND_HI;
            PH_SEND_HI: begin
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bit_inc;
              if (bit_inc >= 4'd8) begin
                wait_nxt  = '0;
                phase_nxt = PH_ACK_REL;
              end else begin
                phase_nxt = PH_SEND_LO;
              end
            end
            PH_ACK_REL: phase_nxt = PH_ACK_POLL;
            PH_ACK_POLL: begin
              if (!item.sda_in) begin
                do_ack = 1'b1;
              end else begin
                wait_nxt = wait_inc;
                if (wait_inc >= cfg.ack_tmo) begin
                  ack_flag_nxt = 1'b1;
                  do_ack       = 1'b1;
                end
              end
            end
            PH_RS:      phase_nxt = PH_START1;
            PH_RECV_LO: phase_nxt = PH_RECV_HI;
            PH_RECV_HI: begin
              shift_nxt   = shift_in;
              bit_cnt_nxt = bit_inc;
              if (bit_inc >= 4'd8) begin
                res.rd_byte  = shift_in;
                res.rd_valid = 1'b1;
                byte_cnt_nxt = bc_inc;
                res.rd_last  = (bc_inc >= BC_W'(len_r));
                phase_nxt    = PH_MACK_LO;
              end else begin
                phase_nxt = PH_RECV_LO;
              end
            end
            PH_MACK_LO: phase_nxt = PH_MACK_HI;
            PH_MACK_HI: begin
              if (byte_cnt_r < BC_W'(len_r)) begin
                bit_cnt_nxt = '0;
                shift_nxt   = '0;
                phase_nxt   = PH_RECV_LO;
              end else begin
                phase_nxt = PH_STOP_A;
              end
            end
            PH_STOP_A: phase_nxt = PH_STOP_B;
            PH_STOP_B: phase_nxt = PH_STOP_C;
            default:   phase_nxt = PH_IDLE;
          endcase
        end
      endcase
    end

    // Next byte after an acknowledge (or its timeout)
    if (do_ack) begin
      if (byte_cnt_r == '0) begin
        shift_nxt    = reg_addr_r;
        byte_cnt_nxt = BC_W'(1);
        bit_cnt_nxt  = '0;
        phase_nxt    = PH_SEND_LO;
      end else if (byte_cnt_r == BC_W'(1)) begin
        if (is_read_r) begin
          phase_nxt = PH_RS;
        end else if (len_r == '0) begin
          phase_nxt = PH_STOP_A;
        end else begin
          shift_nxt    = buf_rd_data;
          byte_cnt_nxt = BC_W'(2);
          bit_cnt_nxt  = '0;
          phase_nxt    = PH_SEND_LO;
        end
      end else if (is_read_r) begin
        byte_cnt_nxt = '0;
        bit_cnt_nxt  = '0;
        shift_nxt    = '0;
        phase_nxt    = PH_RECV_LO;
      end else if (idx_m1 < BC_W'(len_r)) begin
        shift_nxt    = buf_rd_data;
        byte_cnt_nxt = bc_inc;
        bit_cnt_nxt  = '0;
        phase_nxt    = PH_SEND_LO;
      end else begin
        phase_nxt = PH_STOP_A;
      end
    end

    res.ack_missing = ack_flag_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      byte_cnt_r <= '0;
      shift_r    <= '0;
      fill_r     <= '0;
      wait_r     <= '0;
      reg_addr_r <= '0;
      len_r      <= '0;
      is_read_r  <= 1'b0;
      ack_flag_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      fill_r     <= fill_nxt;
      wait_r     <= wait_nxt;
      reg_addr_r <= reg_addr_nxt;
      len_r      <= len_nxt;
      is_read_r  <= is_read_nxt;
      ack_flag_r <= ack_flag_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cmb_checker.sv =====
// Port-level checks for the I2C register-burst master, bound to the top level.
// Depends on i2c_master_register_burst.
`default_nettype none

module i2cmb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_scl_level,
  input wire logic       out_sda_level,
  input wire logic       out_sda_listen,
  input wire logic [7:0] out_rd_byte,
  input wire logic       out_rd_valid,
  input wire logic       out_rd_last,
  input wire logic       out_busy_res
);

  // last-byte flag only comes with a read byte
  a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_last |-> out_rd_valid)
    else $error("rd_last without rd_valid");

  // read bytes complete on a listening SCL-high slot
  a_read_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_valid |-> out_scl_level && out_sda_listen)
    else $error("read byte outside SCL-high listen slot");

  // master never pulls SDA low while listening
  a_listen_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sda_listen |-> out_sda_level)
    else $error("SDA driven while listening");

  // a beat that leaves the bus idle was played with both lines high
  a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_level && out_sda_level && !out_sda_listen)
    else $error("idle result with bus lines not released");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rd_byte))
    else $error("result beat changed under stall");

endmodule

bind i2c_master_register_burst i2cmb_checker u_i2cmb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_scl_level  (out_scl_level),
  .out_sda_level  (out_sda_level),
  .out_sda_listen (out_sda_listen),
  .out_rd_byte    (out_rd_byte),
  .out_rd_valid   (out_rd_valid),
  .out_rd_last    (out_rd_last),
  .out_busy_res   (out_busy_res)
);

`default_nettype wire
